### rtl/core/bsa_pkg.sv
package bsa_pkg;

    localparam int SLOT_COUNT    = 256;
    localparam int WORD_COUNT    = 4;
    localparam int BITS_PER_WORD = 64;
    localparam int ID_SPACE      = 1024;

    localparam int ID_W    = 10;
    localparam int COUNT_W = 11;
    localparam int BIT_W   = 6;
    localparam int WIDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // lowest of the slot count, the bitmap capacity and the id space
    localparam int CAP_SLOTS    = WORD_COUNT * BITS_PER_WORD;
    localparam int LIMIT_A      = (CAP_SLOTS < SLOT_COUNT) ? CAP_SLOTS : SLOT_COUNT;
    localparam int USABLE_LIMIT = (ID_SPACE < LIMIT_A) ? ID_SPACE : LIMIT_A;
    localparam int LAST_WORD    = (USABLE_LIMIT - 1) / BITS_PER_WORD;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOT_USED = 2'd3;

    typedef struct packed {
        logic       load;       // capture request, set word index
        logic       set_bit;    // grant the found slot
        logic       clr_bit;    // release the requested slot
        logic       next_word;  // move scan to the next word
        logic       emit;       // write the output register
        logic [1:0] code;       // status to emit
    } bsa_cmd_t;

    typedef struct packed {
        logic is_release;
        logic hit;
        logic last_word;
        logic range_err;
        logic bit_used;
        logic out_free;
    } bsa_stat_t;

    // usable bits of word w
    function automatic logic [BITS_PER_WORD-1:0] usable_mask(input logic [WIDX_W-1:0] w);
        logic [BITS_PER_WORD-1:0] m;
        int                       b;
        m = '0;
        for (b = 0; b < BITS_PER_WORD; b++)
        begin
            m[b] = ((int'(w) * BITS_PER_WORD + b) < USABLE_LIMIT);
        end
        return m;
    endfunction

endpackage

### rtl/core/bsa_ctrl.sv
module bsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsa_pkg::bsa_stat_t stat,
    output bsa_pkg::bsa_cmd_t  cmd
);
    import bsa_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_WORK
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (stat.out_free)
                begin
                    if (stat.is_release)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                        priority if (stat.range_err)
                            cmd.code = ST_RANGE;
                        else if (!stat.bit_used)
                            cmd.code = ST_NOT_USED;
                        else
                        begin
                            cmd.code    = ST_OK;
                            cmd.clr_bit = 1'b1;
                        end
                    end
                    else
                    begin
                        priority if (stat.hit)
                        begin
                            cmd.set_bit = 1'b1;
                            cmd.emit    = 1'b1;
                            cmd.code    = ST_OK;
                            state_next  = S_IDLE;
                        end
                        else if (stat.last_word)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.code   = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else
                            cmd.next_word = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/bsa_datapath.sv
module bsa_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       opcode,
    input  logic [bsa_pkg::ID_W-1:0]   slot_id,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [1:0]                 status,
    output logic [bsa_pkg::ID_W-1:0]   granted_id,
    output logic [bsa_pkg::COUNT_W-1:0] live_count,
    input  bsa_pkg::bsa_cmd_t          cmd,
    output bsa_pkg::bsa_stat_t         stat
);
    import bsa_pkg::*;

    logic [BITS_PER_WORD-1:0] occ_reg [WORD_COUNT];
    logic [COUNT_W-1:0]       count_reg;
    logic [WIDX_W-1:0]        widx_reg;
    logic                     op_reg;
    logic [ID_W-1:0]          slot_reg;

    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [ID_W-1:0]          granted_reg;
    logic [COUNT_W-1:0]       live_reg;

    logic [BITS_PER_WORD-1:0] cur_word;
    logic [BITS_PER_WORD-1:0] free_bits;
    logic [BIT_W-1:0]         free_idx;
    logic [BIT_W-1:0]         slot_bit;
    logic [COUNT_W-1:0]       count_next;
    logic [ID_W-1:0]          id_next;

    assign cur_word  = occ_reg[widx_reg];
    assign free_bits = ~cur_word & usable_mask(widx_reg);
    assign slot_bit  = slot_reg[BIT_W-1:0];

    // lowest free bit of the current word
    always_comb
    begin
        free_idx = '0;
        for (int b = BITS_PER_WORD - 1; b >= 0; b--)
        begin
            if (free_bits[b])
                free_idx = BIT_W'(b);
        end
    end

    assign stat.is_release = op_reg;
    assign stat.hit        = |free_bits;
    assign stat.last_word  = (widx_reg == WIDX_W'(LAST_WORD));
    assign stat.range_err  = ({1'b0, slot_reg} >= (ID_W + 1)'(USABLE_LIMIT));
    assign stat.bit_used   = cur_word[slot_bit];
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.set_bit)
            count_next = count_reg + COUNT_W'(1);
        else if (cmd.clr_bit)
            count_next = count_reg - COUNT_W'(1);
    end

    assign id_next = cmd.set_bit ? ((ID_W'(widx_reg) << BIT_W) | ID_W'(free_idx)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
                occ_reg[w] <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_bit)
                occ_reg[widx_reg][free_idx] <= 1'b1;
            else if (cmd.clr_bit)
                occ_reg[widx_reg][slot_bit] <= 1'b0;
            count_reg <= count_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            slot_reg <= slot_id;
            widx_reg <= opcode ? slot_id[BIT_W +: WIDX_W] : '0;
        end
        else if (cmd.next_word)
            widx_reg <= widx_reg + WIDX_W'(1);
        if (cmd.emit)
        begin
            status_reg  <= cmd.code;
            granted_reg <= id_next;
            live_reg    <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;
    assign live_count = live_reg;

endmodule

### rtl/core/bitmap_slot_allocator_core.sv
// first-fit slot allocator over an occupancy bitmap of 64-bit words. a word
// with opcode 0 grants the lowest free slot (status ok, granted_id, new live
// count) or reports no free slot; opcode 1 releases slot_id, reporting out of
// range or not allocated when it cannot. one result word per request. the
// block takes one request at a time: a release is accepted in the idle state and
// emits its result word at its work step once the output register is free; an
// allocate scans from word 0, one bitmap word per cycle through a 64-bit priority
// encoder while the output register is free, and emits its result when it finds
// a free bit or reaches the last usable word. a finished result sits in an output
// register, so the next request is accepted while it waits; a result still waiting
// there holds the next request at every work step, so the scan does not advance.
// bitmap and count clear at reset.
module bitmap_slot_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [bsa_pkg::ID_W-1:0]    slot_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [bsa_pkg::ID_W-1:0]    granted_id,
    output logic [bsa_pkg::COUNT_W-1:0] live_count
);
    import bsa_pkg::*;

    // command and status between sequencer and datapath
    bsa_cmd_t  cmd;
    bsa_stat_t stat;

    // sequencer: idle, then scan or release step
    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bitmap, live count, scan index and output register
    bsa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (opcode),
        .slot_id    (slot_id),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .granted_id (granted_id),
        .live_count (live_count),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

### tb/bitmap_slot_allocator_core_tb.sv
module bitmap_slot_allocator_core_tb;

    import bsa_pkg::*;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } req_op_t;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_kind_t;

    typedef struct packed {
        logic [1:0]         code;
        logic [ID_W-1:0]    slot;
        logic [COUNT_W-1:0] live;
    } alloc_result_t;

    typedef struct packed {
        req_op_t            op;
        logic [ID_W-1:0]    id;
        logic               has_want;
        alloc_result_t      want;
    } stim_row_t;

    localparam int N_RANDOM     = 1000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 2 * WORD_COUNT + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIRECTED   = 21;

    localparam logic [ID_W-1:0] TOP_ID    = {ID_W{1'b1}};
    localparam logic [ID_W-1:0] LIMIT_ID  = ID_W'(USABLE_LIMIT);
    localparam logic [ID_W-1:0] LAST_SLOT = ID_W'(USABLE_LIMIT - 1);

    // rows with has_want set carry an expectation typed in by hand,
    // the others are checked against the occupancy predictor
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{OP_RELEASE, 10'd0,     1'b1, '{ST_NOT_USED, 10'd0, 11'd0}},
        '{OP_RELEASE, TOP_ID,    1'b1, '{ST_RANGE,    10'd0, 11'd0}},
        '{OP_RELEASE, LIMIT_ID,  1'b0, '0},
        '{OP_RELEASE, LAST_SLOT, 1'b1, '{ST_NOT_USED, 10'd0, 11'd0}},
        '{OP_ALLOC,   TOP_ID,    1'b1, '{ST_OK,       10'd0, 11'd1}},
        '{OP_ALLOC,   10'd0,     1'b1, '{ST_OK,       10'd1, 11'd2}},
        '{OP_ALLOC,   10'd0,     1'b1, '{ST_OK,       10'd2, 11'd3}},
        '{OP_RELEASE, 10'd1,     1'b1, '{ST_OK,       10'd0, 11'd2}},
        '{OP_RELEASE, 10'd1,     1'b1, '{ST_NOT_USED, 10'd0, 11'd2}},
        '{OP_ALLOC,   10'd0,     1'b1, '{ST_OK,       10'd1, 11'd3}},
        '{OP_RELEASE, TOP_ID,    1'b1, '{ST_RANGE,    10'd0, 11'd3}},
        '{OP_RELEASE, 10'd2,     1'b0, '0},
        '{OP_RELEASE, 10'd0,     1'b0, '0},
        '{OP_RELEASE, 10'd1,     1'b0, '0},
        '{OP_RELEASE, 10'd0,     1'b0, '0},
        '{OP_ALLOC,   10'h2AA,   1'b0, '0},
        '{OP_ALLOC,   10'h155,   1'b0, '0},
        '{OP_RELEASE, 10'h155,   1'b0, '0},
        '{OP_RELEASE, 10'd63,    1'b0, '0},
        '{OP_RELEASE, 10'd1,     1'b0, '0},
        '{OP_RELEASE, 10'd0,     1'b0, '0}
    };

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               opcode     = 1'b0;
    logic [ID_W-1:0]    slot_id    = '0;
    logic               out_ready  = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [1:0]         status;
    logic [ID_W-1:0]    granted_id;
    logic [COUNT_W-1:0] live_count;

    // predictor state: one bit per slot and the live count
    logic [CAP_SLOTS-1:0] slot_map     = '0;
    logic [COUNT_W-1:0]   slots_in_use = '0;

    alloc_result_t pending_results [$];
    int            fail_count   = 0;
    int            results_seen = 0;
    int            random_sent  = 0;
    int            cycle_count  = 0;
    bit            sender_idles = 1'b1;

    always #1 clk = ~clk;

    bitmap_slot_allocator_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .slot_id    (slot_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .granted_id (granted_id),
        .live_count (live_count)
    );

    // first-fit grant or checked release, updating the slot map
    function automatic alloc_result_t predict_request(input req_op_t op,
                                                      input logic [ID_W-1:0] id);
        alloc_result_t r;
        int            s;
        r = '{code: ST_FULL, slot: '0, live: '0};
        if (op == OP_ALLOC)
        begin
            for (s = 0; s < USABLE_LIMIT && r.code != ST_OK; s++)
            begin
                if (!slot_map[s])
                begin
                    slot_map[s]  = 1'b1;
                    slots_in_use = slots_in_use + 1'b1;
                    r.code       = ST_OK;
                    r.slot       = ID_W'(s);
                end
            end
        end
        else if (int'(id) >= USABLE_LIMIT)
        begin
            r.code = ST_RANGE;
        end
        else if (!slot_map[id])
        begin
            r.code = ST_NOT_USED;
        end
        else
        begin
            slot_map[id] = 1'b0;
            slots_in_use = slots_in_use - 1'b1;
            r.code       = ST_OK;
        end
        r.live = slots_in_use;
        return r;
    endfunction

    // a random slot that is in use, scanning onward from a random start
    function automatic logic [ID_W-1:0] pick_used_slot();
        int              start;
        int              k;
        int              s;
        bit              found;
        logic [ID_W-1:0] pick;
        start = $urandom_range(0, USABLE_LIMIT - 1);
        pick  = ID_W'(start);
        found = 1'b0;
        for (k = 0; k < USABLE_LIMIT && !found; k++)
        begin
            s = (start + k) % USABLE_LIMIT;
            if (slot_map[s])
            begin
                pick  = ID_W'(s);
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    // offer one request word; valid is only lowered when a gap follows
    task automatic send_request(input req_op_t op, input logic [ID_W-1:0] id,
                                input logic has_want, input alloc_result_t want);
        int            gap;
        alloc_result_t guess;
        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        slot_id  <= id;
        do @(posedge clk); while (!in_ready);
        guess = predict_request(op, id);
        pending_results.push_back(has_want ? want : guess);
    endtask

    // alloc_pct of the words allocate; releases mostly hit used slots
    task automatic send_random(input int alloc_pct);
        logic [ID_W-1:0] id;
        int              roll;
        id   = ID_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
        begin
            send_request(OP_ALLOC, id, 1'b0, '0);
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                id = pick_used_slot();
            else if (roll < 92)
                id = ID_W'($urandom_range(0, USABLE_LIMIT - 1));
            send_request(OP_RELEASE, id, 1'b0, '0);
        end
        random_sent++;
    endtask

    task automatic run_phase(input phase_kind_t kind);
        int n;
        unique case (kind)
            PH_FILL:
            begin
                while (slots_in_use != COUNT_W'(USABLE_LIMIT))
                    send_random(90);
                // keep knocking on a full map
                repeat ($urandom_range(4, 12)) send_random(80);
            end
            PH_DRAIN:
            begin
                while (slots_in_use != '0)
                    send_random(10);
                repeat ($urandom_range(4, 12)) send_random(20);
            end
            default:
            begin
                n = $urandom_range(60, 150);
                repeat (n) send_random(50);
            end
        endcase
    endtask

    // stimulus
    initial
    begin
        int          i;
        phase_kind_t kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].id,
                         DIRECTED_ROWS[i].has_want, DIRECTED_ROWS[i].want);
        end
        kind = PH_FILL;
        while (random_sent < N_RANDOM)
        begin
            sender_idles = ($urandom_range(0, 2) != 0);
            run_phase(kind);
            // sender goes quiet until every result is back
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0) @(posedge clk);
            unique case (kind)
                PH_FILL:  kind = PH_DRAIN;
                PH_DRAIN: kind = PH_MIXED;
                default:  kind = PH_FILL;
            endcase
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("bitmap_slot_allocator_core_tb passed");
        else
            $display("bitmap_slot_allocator_core_tb failed");
        $finish;
    end

    // result side: random stalls, two long hold-offs, field compare
    initial
    begin
        alloc_result_t want;
        int            gap;
        bit            rx_idles;
        rx_idles = 1'b1;
        wait (rst_n);
        forever
        begin
            if (results_seen % 50 == 0)
                rx_idles = ($urandom_range(0, 2) != 0);
            if (results_seen == 30 || results_seen == 600)
                gap = LONG_HOLD;
            else
                gap = rx_idles ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, status %0d id %0d count %0d",
                         $time, status, granted_id, live_count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.code)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.code, status);
                    fail_count++;
                end
                if (granted_id !== want.slot)
                begin
                    $display("%0t: granted_id expected %0d actual %0d",
                             $time, want.slot, granted_id);
                    fail_count++;
                end
                if (live_count !== want.live)
                begin
                    $display("%0t: live_count expected %0d actual %0d",
                             $time, want.live, live_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_slot_allocator_core_tb failed");
            $finish;
        end
    end

endmodule

### filelist.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_ctrl.sv
rtl/core/bsa_datapath.sv
rtl/core/bitmap_slot_allocator_core.sv
tb/bitmap_slot_allocator_core_tb.sv
